[sv/sle_pkg.sv]
package sle_pkg;

  // Coordinate and derived widths
  localparam int CW   = 32;          // coordinate
  localparam int DW   = CW + 1;      // coordinate difference magnitude
  localparam int SW   = 2 * DW;      // sum of squares
  localparam int RW   = DW;          // square root result
  localparam int REMW = RW + 2;      // square root remainder
  localparam int LW   = 33;          // length
  localparam int PW   = DW + CW;     // offset times target length
  localparam int NW   = PW + 2;      // divider numerator
  localparam int QW   = DW;          // quotient bits
  localparam int DDW  = LW + 1;      // divisor
  localparam int DRW  = DDW + 1;     // divider remainder
  localparam int XW   = CW + 3;      // new end before saturation

  // Configuration register indexes
  localparam logic [1:0] CFG_TARGET = 2'd0;
  localparam logic [1:0] CFG_TOL    = 2'd1;

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
  } seg_t;

  typedef struct packed {
    logic signed [CW-1:0] new_end_x;
    logic signed [CW-1:0] new_end_y;
    logic [LW-1:0]        cur_len;
    logic [LW-1:0]        length_error;
    logic                 satisfied;
    logic                 degenerate;
    logic                 clipped;
  } res_t;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic                 neg_x;
    logic                 neg_y;
    logic                 degen;
    logic [PW-1:0]        px;
    logic [PW-1:0]        py;
  } sq_side_t;

  typedef struct packed {
    logic          valid;
    logic [SW-1:0] rad;
    logic [REMW-1:0] rem;
    logic [RW-1:0] root;
    sq_side_t      side;
  } sq_st_t;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic                 neg_x;
    logic                 neg_y;
    logic                 degen;
    logic [LW-1:0]        len;
  } dv_side_t;

  typedef struct packed {
    logic           valid;
    logic [DDW-1:0] d;
    logic [DRW-1:0] rem_x;
    logic [DRW-1:0] rem_y;
    logic [QW-1:0]  n_x;
    logic [QW-1:0]  n_y;
    logic [QW-1:0]  q_x;
    logic [QW-1:0]  q_y;
    dv_side_t       side;
  } dv_st_t;

endpackage

[sv/sle_sqrt_cell.sv]
module sle_sqrt_cell import sle_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  sq_st_t prev,
  output sq_st_t cur
);

  logic [REMW+1:0] rem2;
  logic [REMW+1:0] trial;
  sq_st_t          cur_next;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    rem2  = {prev.rem, prev.rad[SW-1 -: 2]};
    trial = (REMW+2)'({prev.root, 2'b01});
    cur_next       = prev;
    cur_next.rad   = {prev.rad[SW-3:0], 2'b00};
    if (rem2 >= trial) begin
      cur_next.rem  = REMW'(rem2 - trial);
      cur_next.root = {prev.root[RW-2:0], 1'b1};
    end else begin
      cur_next.rem  = REMW'(rem2);
      cur_next.root = {prev.root[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (en) begin
      cur <= cur_next;
    end
  end

endmodule

[sv/sle_div_cell.sv]
module sle_div_cell import sle_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  dv_st_t prev,
  output dv_st_t cur
);

  logic [DRW:0] rx;
  logic [DRW:0] ry;
  logic [DRW:0] dd;
  dv_st_t       cur_next;

  // One quotient bit per lane, shared divisor
  always_comb begin
    rx = {prev.rem_x, prev.n_x[QW-1]};
    ry = {prev.rem_y, prev.n_y[QW-1]};
    dd = (DRW+1)'(prev.d);
    cur_next     = prev;
    cur_next.n_x = {prev.n_x[QW-2:0], 1'b0};
    cur_next.n_y = {prev.n_y[QW-2:0], 1'b0};
    if (rx >= dd) begin
      cur_next.rem_x = DRW'(rx - dd);
      cur_next.q_x   = {prev.q_x[QW-2:0], 1'b1};
    end else begin
      cur_next.rem_x = DRW'(rx);
      cur_next.q_x   = {prev.q_x[QW-2:0], 1'b0};
    end
    if (ry >= dd) begin
      cur_next.rem_y = DRW'(ry - dd);
      cur_next.q_y   = {prev.q_y[QW-2:0], 1'b1};
    end else begin
      cur_next.rem_y = DRW'(ry);
      cur_next.q_y   = {prev.q_y[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (en) begin
      cur <= cur_next;
    end
  end

endmodule

[sv/segment_length_enforce_top.sv]
// Rescales a segment to the configured target length. One segment is accepted per
// clock while seg_stall is low; a result passes the difference, product and sum registers,
// the 33-cell square root chain, the rounding and divider-head registers, the 33-cell
// divider chain (one result bit per cell) and the output register. When a result is held
// at the output the whole pipeline holds and seg_stall rises in the same cycle. Write the
// target length (index 0) and tolerance (index 1) only while no segment is in flight.
module segment_length_enforce_top import sle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        seg_valid,
  output logic        seg_stall,
  input  seg_t        seg,
  output logic        res_valid,
  input  logic        res_stall,
  output res_t        res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [CW-1:0] tgt_len;
  logic [CW-1:0] tolerance;
  logic          en;

  // stage 0: differences
  logic                 v0;
  logic [DW-1:0]        ax0, ay0;
  logic                 nx0, ny0;
  logic signed [CW-1:0] sx0, sy0;
  logic signed [DW:0]   dx, dy;

  // stage 1: products
  logic                 v1;
  logic [SW-1:0]        sqx1, sqy1;
  sq_side_t             side1;

  sq_st_t sq [RW+1];

  // rounding stage
  logic          vr;
  logic [LW-1:0] lenr;
  logic [PW-1:0] pxr, pyr;
  sq_side_t      sider;
  logic [LW-1:0] len_next;

  dv_st_t dv [QW+1];
  logic [NW-1:0] numx, numy;

  // final stage
  logic signed [QW:0]   offx, offy;
  logic signed [XW-1:0] ex, ey;
  logic [LW-1:0]        err;
  logic                 clip_x, clip_y;
  logic signed [CW-1:0] satx, saty;
  res_t                 res_next;

  localparam logic signed [XW-1:0] SMAX = XW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [XW-1:0] SMIN = -SMAX - XW'(1);

  assign en        = !(res_valid && res_stall);
  assign seg_stall = !en;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_len   <= CW'(65536);
      tolerance <= CW'(66);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET: tgt_len   <= cfg_data;
        CFG_TOL:    tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dx = $signed({{2{seg.end_x[CW-1]}}, seg.end_x}) -
              $signed({{2{seg.start_x[CW-1]}}, seg.start_x});
  assign dy = $signed({{2{seg.end_y[CW-1]}}, seg.end_y}) -
              $signed({{2{seg.start_y[CW-1]}}, seg.start_y});

  // Capture differences and magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0  <= seg_valid;
      nx0 <= dx[DW];
      ny0 <= dy[DW];
      ax0 <= dx[DW] ? DW'(-dx) : DW'(dx);
      ay0 <= dy[DW] ? DW'(-dy) : DW'(dy);
      sx0 <= seg.start_x;
      sy0 <= seg.start_y;
    end
  end

  // Square magnitudes and scale them by the target
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1          <= v0;
      sqx1        <= SW'(ax0) * SW'(ax0);
      sqy1        <= SW'(ay0) * SW'(ay0);
      side1.px    <= PW'(ax0) * PW'(tgt_len);
      side1.py    <= PW'(ay0) * PW'(tgt_len);
      side1.sx    <= sx0;
      side1.sy    <= sy0;
      side1.neg_x <= nx0;
      side1.neg_y <= ny0;
      side1.degen <= (ax0 == '0) && (ay0 == '0);
    end
  end

  // Sum squares into the head of the root chain
  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].valid <= 1'b0;
    end else if (en) begin
      sq[0].valid <= v1;
      sq[0].rad   <= sqx1 + sqy1;
      sq[0].rem   <= '0;
      sq[0].root  <= '0;
      sq[0].side  <= side1;
    end
  end

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    sle_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .prev (sq[i]),
      .cur  (sq[i+1])
    );
  end

  // Round to nearest: step up when the remainder exceeds the root
  assign len_next = (sq[RW].rem > REMW'(sq[RW].root)) ? LW'(sq[RW].root) + LW'(1)
                                                    : LW'(sq[RW].root);

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else if (en) begin
      vr    <= sq[RW].valid;
      lenr  <= len_next;
      pxr   <= sq[RW].side.px;
      pyr   <= sq[RW].side.py;
      sider <= sq[RW].side;
    end
  end

  // Form numerators 2*p + L over divisor 2*L
  assign numx = NW'({pxr, 1'b0}) + NW'(lenr);
  assign numy = NW'({pyr, 1'b0}) + NW'(lenr);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else if (en) begin
      dv[0].valid      <= vr;
      dv[0].d          <= {lenr, 1'b0};
      dv[0].rem_x      <= DRW'(numx[NW-1:QW]);
      dv[0].rem_y      <= DRW'(numy[NW-1:QW]);
      dv[0].n_x        <= numx[QW-1:0];
      dv[0].n_y        <= numy[QW-1:0];
      dv[0].q_x        <= '0;
      dv[0].q_y        <= '0;
      dv[0].side.sx    <= sider.sx;
      dv[0].side.sy    <= sider.sy;
      dv[0].side.neg_x <= sider.neg_x;
      dv[0].side.neg_y <= sider.neg_y;
      dv[0].side.degen <= sider.degen;
      dv[0].side.len   <= lenr;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    sle_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .prev (dv[i]),
      .cur  (dv[i+1])
    );
  end

  // Apply signed offsets, saturate, and grade the length
  always_comb begin
    offx = dv[QW].side.neg_x ? -$signed({1'b0, dv[QW].q_x}) : $signed({1'b0, dv[QW].q_x});
    offy = dv[QW].side.neg_y ? -$signed({1'b0, dv[QW].q_y}) : $signed({1'b0, dv[QW].q_y});
    if (dv[QW].side.degen) begin
      ex = XW'(dv[QW].side.sx) + $signed(XW'(tgt_len));
      ey = XW'(dv[QW].side.sy);
    end else begin
      ex = XW'(dv[QW].side.sx) + XW'(offx);
      ey = XW'(dv[QW].side.sy) + XW'(offy);
    end
    clip_x = (ex > SMAX) || (ex < SMIN);
    clip_y = (ey > SMAX) || (ey < SMIN);
    satx = (ex > SMAX) ? CW'(SMAX) : (ex < SMIN) ? CW'(SMIN) : CW'(ex);
    saty = (ey > SMAX) ? CW'(SMAX) : (ey < SMIN) ? CW'(SMIN) : CW'(ey);
    err  = (dv[QW].side.len >= LW'(tgt_len)) ? dv[QW].side.len - LW'(tgt_len)
                                             : LW'(tgt_len) - dv[QW].side.len;
    res_next.new_end_x    = satx;
    res_next.new_end_y    = saty;
    res_next.cur_len      = dv[QW].side.len;
    res_next.length_error = err;
    res_next.satisfied    = err <= LW'(tolerance);
    res_next.degenerate   = dv[QW].side.degen;
    res_next.clipped      = clip_x || clip_y;
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= dv[QW].valid;
      res       <= res_next;
    end
  end

endmodule

[sv/sle_check.sv]
module sle_check import sle_pkg::*; (
  input logic clk,
  input logic rst,
  input logic seg_valid,
  input logic seg_stall,
  input logic res_valid,
  input logic res_stall,
  input res_t res
);

  // Input side backs up exactly when a result is held
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    seg_stall == (res_valid && res_stall))
    else $error("input stall does not follow held result");

  // A held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("held result changed");

  // Zero-length segments report zero length
  a_degen: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.degenerate |-> res.cur_len == '0)
    else $error("degenerate result with nonzero length");

  // Reset empties the output
  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind segment_length_enforce_top sle_check u_sle_check (
  .clk       (clk),
  .rst       (rst),
  .seg_valid (seg_valid),
  .seg_stall (seg_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
